### hw/rtl/ouart_pkg.sv
// Shared types and fixed constants for the oversampled UART transceiver.
`default_nettype none

package ouart_pkg;

    localparam int CNT_W      = 4;   // tick and bit counters
    localparam int DATA_W     = 8;   // one character
    localparam int STORE_W    = 16;  // receive sample store entries
    localparam int BIT_SEL_W  = 3;   // selects one data bit

    typedef struct packed {
        logic              rx_line;
        logic              tx_load;
        logic [DATA_W-1:0] tx_byte;
    } ouart_in_t;

    typedef struct packed {
        logic              tx_line;
        logic              tx_ready;
        logic              tx_done;
        logic              rx_valid;
        logic [DATA_W-1:0] rx_byte;
    } ouart_out_t;

    // Transmitter status after one tick
    typedef struct packed {
        logic line;
        logic ready;
        logic done;
    } ouart_tx_stat_t;

    // Receiver status after one tick
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] rx_byte;
    } ouart_rx_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ouart_if.sv
// Valid/ready channel interfaces for tick input and result output.
`default_nettype none

interface ouart_in_if;
    import ouart_pkg::*;

    logic      valid;
    logic      ready;
    ouart_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ouart_out_if;
    import ouart_pkg::*;

    logic       valid;
    logic       ready;
    ouart_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ouart_tx.sv
// Transmitter: start bit, data bits LSB first, stop bit, one step per tick.
`default_nettype none

module ouart_tx
    import ouart_pkg::*;
#(
    parameter int SAMPLES_PER_BIT = 8,
    parameter int FRAME_BITS      = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              tx_load,
    input  logic [DATA_W-1:0] tx_byte,
    output ouart_tx_stat_t    stat
);

    localparam logic [CNT_W-1:0] SPB_M1 = CNT_W'(SAMPLES_PER_BIT - 1);
    localparam logic [CNT_W-1:0] FB     = CNT_W'(FRAME_BITS);
    localparam logic [CNT_W-1:0] FB_M1  = CNT_W'(FRAME_BITS - 1);

    logic              busy_reg, busy_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              lvl_reg, lvl_next;
    logic              done;
    logic [CNT_W-1:0]  idx_m1;

    always_comb
    begin
        busy_next = busy_reg;
        data_next = data_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        lvl_next  = lvl_reg;
        done      = 1'b0;
        idx_m1    = idx_reg - CNT_W'(1);

        if (tx_load && !busy_reg)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            cnt_next  = '0;
            data_next = tx_byte;
        end

        if (busy_next)
        begin
            if (cnt_next != '0)
            begin
                if (cnt_next < SPB_M1)
                    cnt_next = cnt_next + CNT_W'(1);
                else
                    cnt_next = '0;
            end
            else if (idx_next == '0)
            begin
                lvl_next = 1'b0;
                cnt_next = CNT_W'(1);
                idx_next = CNT_W'(1);
            end
            else if (idx_next < FB_M1)
            begin
                // idx_next equals idx_reg here: a fresh load always starts at zero
                lvl_next = data_next[idx_m1[BIT_SEL_W-1:0]];
                cnt_next = CNT_W'(1);
                idx_next = idx_next + CNT_W'(1);
            end
            else if (idx_next == FB_M1)
            begin
                lvl_next = 1'b1;
                cnt_next = CNT_W'(1);
                idx_next = idx_next + CNT_W'(1);
            end
            else
            begin
                done      = (idx_next == FB);
                busy_next = 1'b0;
                idx_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            data_reg <= '0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            lvl_reg  <= 1'b1;
        end
        else if (step)
        begin
            busy_reg <= busy_next;
            data_reg <= data_next;
            idx_reg  <= idx_next;
            cnt_reg  <= cnt_next;
            lvl_reg  <= lvl_next;
        end
    end

    assign stat.line  = lvl_next;
    assign stat.ready = !busy_next;
    assign stat.done  = done;

endmodule

`default_nettype wire

### hw/rtl/ouart_rx.sv
// Receiver: start hunt with two majority checks, mid-bit majority decode.
`default_nettype none

module ouart_rx
    import ouart_pkg::*;
#(
    parameter int SAMPLES_PER_BIT     = 8,
    parameter int START_CHECK_SAMPLES = 3,
    parameter int FRAME_BITS          = 10
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           rx_line,
    output ouart_rx_stat_t stat
);

    localparam int               MID    = (SAMPLES_PER_BIT - 1) / 2;
    localparam logic [CNT_W-1:0] SPB_M1 = CNT_W'(SAMPLES_PER_BIT - 1);
    localparam logic [CNT_W-1:0] SCS    = CNT_W'(START_CHECK_SAMPLES);
    localparam logic [CNT_W-1:0] FB     = CNT_W'(FRAME_BITS);
    localparam logic [CNT_W-1:0] MID_LO = CNT_W'(MID - 1);
    localparam logic [CNT_W-1:0] MID_C  = CNT_W'(MID);
    localparam logic [CNT_W-1:0] MID_HI = CNT_W'(MID + 1);

    logic               frame_reg, frame_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STORE_W-1:0] smp_reg, smp_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic               vote_start;
    logic               vote_mid;
    logic               valid;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   bit_pos;

    function automatic logic maj3(input logic a, input logic b, input logic c);
        maj3 = (a & b) | (a & c) | (b & c);
    endfunction

    assign vote_start = maj3(smp_reg[0], smp_reg[1], smp_reg[2]);
    assign vote_mid   = maj3(smp_reg[MID_LO], smp_reg[MID_C], smp_reg[MID_HI]);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign bit_pos    = idx_inc - CNT_W'(2);

    always_comb
    begin
        frame_next = frame_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        smp_next   = smp_reg;
        data_next  = data_reg;
        valid      = 1'b0;

        if (!frame_reg)
        begin
            if (cnt_reg == '0)
            begin
                if (!rx_line)
                begin
                    smp_next[cnt_reg] = rx_line;
                    cnt_next          = cnt_reg + CNT_W'(1);
                end
            end
            else if (cnt_reg < SCS)
            begin
                smp_next[cnt_reg] = rx_line;
                cnt_next          = cnt_reg + CNT_W'(1);
            end
            else if (cnt_reg == SCS)
            begin
                // early start check
                if (!vote_start)
                begin
                    smp_next[cnt_reg] = rx_line;
                    cnt_next          = cnt_reg + CNT_W'(1);
                end
                else
                    cnt_next = '0;
            end
            else if (cnt_reg < SPB_M1)
            begin
                smp_next[cnt_reg] = rx_line;
                cnt_next          = cnt_reg + CNT_W'(1);
            end
            else if (cnt_reg == SPB_M1)
            begin
                // mid-bit start confirmation
                if (!vote_mid)
                begin
                    frame_next = 1'b1;
                    idx_next   = CNT_W'(1);
                    data_next  = '0;
                end
                cnt_next = '0;
            end
            else
                cnt_next = '0;
        end
        else if (cnt_reg < SPB_M1)
        begin
            smp_next[cnt_reg] = rx_line;
            cnt_next          = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = '0;
            if (idx_inc < FB)
            begin
                data_next[bit_pos[BIT_SEL_W-1:0]] = vote_mid;
                idx_next                          = idx_inc;
            end
            else
            begin
                // stop bit: deliver only when high
                idx_next   = '0;
                frame_next = 1'b0;
                valid      = vote_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            data_reg  <= '0;
        end
        else if (step)
        begin
            frame_reg <= frame_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            data_reg  <= data_next;
        end
    end

    // sample store: every vote reads entries written earlier in the same bit
    always_ff @(posedge clk)
    begin
        if (step)
            smp_reg <= smp_next;
    end

    assign stat.valid   = valid;
    assign stat.rx_byte = data_next;

endmodule

`default_nettype wire

### hw/rtl/oversampled_uart_transceiver_top.sv
// Top level of the oversampled 8N1 UART transceiver with majority-vote receive.
//
// Usage:
//   tick   : one transfer per oversampling tick, carrying the sampled receive
//            level (rx_line) and an optional transmit load (tx_load, tx_byte).
//            A load is taken only while the transmitter is idle.
//   result : one transfer per accepted tick with the transmit pin level, the
//            transmitter idle flag, the tx_done and rx_valid pulses and the
//            receive data register.
// The result of a tick is computed from its transfer on tick and registered in the
//   result buffer. Throughput: one tick per cycle while tick.ready is high, set by the single
//   register-to-register step of the transmit and receive state.
// A two-entry result buffer (output register plus skid register) sits between
//   the state update and the result channel; tick.ready is a register bit, so
//   up to two results may wait while result.ready is low, after which tick.ready
//   drops until a result transfer frees an entry. No tick is lost or repeated.
// Reset (rst_n low, asynchronous): transmitter idle with the pin high, receiver
//   hunting for a start bit, data registers cleared, result buffer empty.
`default_nettype none

module oversampled_uart_transceiver_top
    import ouart_pkg::*;
#(
    parameter int SAMPLES_PER_BIT     = 8,
    parameter int START_CHECK_SAMPLES = 3,
    parameter int FRAME_BITS          = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    ouart_in_if.sink     tick,
    ouart_out_if.source  result
);

    logic           step;
    ouart_tx_stat_t tx_stat;
    ouart_rx_stat_t rx_stat;
    ouart_out_t     res;

    logic           head_vld_reg;
    logic           skid_vld_reg;
    ouart_out_t     head_reg;
    ouart_out_t     skid_reg;
    logic           pop;

    assign tick.ready = !skid_vld_reg;
    assign step       = tick.valid && tick.ready;

    ouart_tx #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
        .FRAME_BITS      (FRAME_BITS)
    ) u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .tx_load (tick.data.tx_load),
        .tx_byte (tick.data.tx_byte),
        .stat    (tx_stat)
    );

    ouart_rx #(
        .SAMPLES_PER_BIT     (SAMPLES_PER_BIT),
        .START_CHECK_SAMPLES (START_CHECK_SAMPLES),
        .FRAME_BITS          (FRAME_BITS)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_line (tick.data.rx_line),
        .stat    (rx_stat)
    );

    always_comb
    begin
        res.tx_line  = tx_stat.line;
        res.tx_ready = tx_stat.ready;
        res.tx_done  = tx_stat.done;
        res.rx_valid = rx_stat.valid;
        res.rx_byte  = rx_stat.rx_byte;
    end

    assign pop = head_vld_reg && result.ready;

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (pop || !head_vld_reg)
        begin
            if (skid_vld_reg)
            begin
                head_vld_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                head_vld_reg <= step;
        end
        else if (step)
            skid_vld_reg <= 1'b1;
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (pop || !head_vld_reg)
        begin
            if (skid_vld_reg)
                head_reg <= skid_reg;
            else if (step)
                head_reg <= res;
        end
        else if (step)
            skid_reg <= res;
    end

    assign result.valid = head_vld_reg;
    assign result.data  = head_reg;

endmodule

`default_nettype wire
